FILE: hdl/register_memory_execute_unit_top_macros.svh
// Assertion macros shared by the execute unit modules
`ifndef REGISTER_MEMORY_EXECUTE_UNIT_TOP_MACROS_SVH
`define REGISTER_MEMORY_EXECUTE_UNIT_TOP_MACROS_SVH

// Implication that must hold at every clock edge outside reset
`define RMEU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent
`define RMEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/rmeu_pkg.sv
package rmeu_pkg;

   localparam int MemWordsDefault = 512;
   localparam int NumRegsDefault  = 32;
   localparam int FlagReg         = 17;
   localparam int SpReg           = 8;
   localparam int SpReset         = 100;

   localparam logic [5:0] OP_ADD  = 6'd0;
   localparam logic [5:0] OP_SUB  = 6'd1;
   localparam logic [5:0] OP_MOV  = 6'd2;
   localparam logic [5:0] OP_AND  = 6'd3;
   localparam logic [5:0] OP_XOR  = 6'd4;
   localparam logic [5:0] OP_OR   = 6'd5;
   localparam logic [5:0] OP_CMP  = 6'd6;
   localparam logic [5:0] OP_XCHG = 6'd8;
   localparam logic [5:0] OP_PUSH = 6'd9;
   localparam logic [5:0] OP_POP  = 6'd10;
   localparam logic [5:0] OP_MULA = 6'd11;
   localparam logic [5:0] OP_MULB = 6'd12;
   localparam logic [5:0] OP_DIVA = 6'd13;
   localparam logic [5:0] OP_DIVB = 6'd14;
   localparam logic [5:0] OP_JMPA = 6'd15;
   localparam logic [5:0] OP_JE   = 6'd16;
   localparam logic [5:0] OP_JNE  = 6'd17;
   localparam logic [5:0] OP_JG   = 6'd18;
   localparam logic [5:0] OP_JGE  = 6'd19;
   localparam logic [5:0] OP_JL   = 6'd20;
   localparam logic [5:0] OP_JLE  = 6'd21;
   localparam logic [5:0] OP_JMPB = 6'd22;
   localparam logic [5:0] OP_HALT = 6'd63;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_ILLEGAL = 2'd1;
   localparam logic [1:0] ERR_RANGE   = 2'd2;

   typedef enum logic [3:0] {
      CL_ALU, CL_XCHG, CL_PUSH, CL_POP, CL_MUL, CL_DIV, CL_JUMP, CL_HALT,
      CL_NOP, CL_ILLEGAL
   } op_class_type;

   // decoded item handed from the front to the back
   typedef struct packed {
      op_class_type cls;
      logic [5:0]   opcode;
      logic [10:0]  src_field;
      logic [4:0]   dst_reg;
      logic [12:0]  addr;
      logic         src_is_imm;
      logic         dst_is_mem;
   } dec_item_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_MUL, ST_DIV, ST_WB, ST_WB2, ST_DONE
   } exec_state_type;

   // sign-magnitude word to signed value
   function automatic logic signed [32:0] val_of(input logic [31:0] w);
      logic signed [32:0] m;
      m = {2'b00, w[30:0]};
      return w[31] ? -m : m;
   endfunction

   // signed value to sign-magnitude word, magnitude kept at 31 bits
   function automatic logic [31:0] word_of(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
      if (m[30:0] == 31'd0) return 32'd0;
      return {v[63], m[30:0]};
   endfunction

   function automatic logic [1:0] flag_of(input logic [31:0] w);
      if (w == 32'd0) return 2'd0;
      if (w == 32'd1) return 2'd1;
      if (w == 32'd2) return 2'd2;
      return 2'd3;
   endfunction

endpackage

FILE: hdl/register_memory_execute_unit_top.sv
// Execute unit for decoded register/memory instructions. An instruction is
// taken when start is high and busy is low; a two-deep queue lets up to two
// wait while one executes. Each instruction yields one response, shown for
// one cycle with rsp_valid; the receiver cannot stall. After reset the data
// memory is zeroed one word per cycle (MemWords words, 512 by default);
// instructions queue meanwhile and start executing once the pass is done.
// Each instruction is popped from the queue in the idle state; the read state
// decodes it and issues the memory read, and push, jumps, halt, no-ops and
// errors respond from there. ALU ops, exchange and pop then latch operands and
// execute; mul goes through its multiply and write-back states; div goes
// through its restoring divider, one quotient bit per cycle, then write-back.
// The back end takes no new instruction until it is back in idle.
module register_memory_execute_unit_top #(
   parameter int MemWords = rmeu_pkg::MemWordsDefault,
   parameter int NumRegs  = rmeu_pkg::NumRegsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [5:0]         req_opcode,
   input  logic [10:0]        req_src_field,
   input  logic [4:0]         req_dst_reg,
   input  logic [7:0]         req_mem_offset,
   input  logic               req_src_is_imm,
   input  logic               req_dst_is_mem,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_flag_code,
   output logic               rsp_branch_taken,
   output logic signed [31:0] rsp_branch_target,
   output logic               rsp_halted,
   output logic [1:0]         rsp_error
);
   import rmeu_pkg::*;

   logic         q_valid, q_pop;
   dec_item_type q_item;

   rmeu_front u_front (
      .clock, .reset, .start, .busy, .req_opcode, .req_src_field, .req_dst_reg,
      .req_mem_offset, .req_src_is_imm, .req_dst_is_mem,
      .q_valid, .q_item, .q_pop
   );

   rmeu_back #(.MemWords(MemWords), .NumRegs(NumRegs)) u_back (
      .clock, .reset, .q_valid, .q_item, .q_pop, .rsp_valid, .rsp_result_value,
      .rsp_flag_code, .rsp_branch_taken, .rsp_branch_target, .rsp_halted, .rsp_error
   );
endmodule

FILE: hdl/rmeu_ram.sv
module rmeu_ram #(
   parameter int Width = 32,
   parameter int Depth = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/rmeu_front.sv
module rmeu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [5:0]            req_opcode,
   input  logic [10:0]           req_src_field,
   input  logic [4:0]            req_dst_reg,
   input  logic [7:0]            req_mem_offset,
   input  logic                  req_src_is_imm,
   input  logic                  req_dst_is_mem,
   output logic                  q_valid,
   output rmeu_pkg::dec_item_type q_item,
   input  logic                  q_pop
);
   import rmeu_pkg::*;

   // two-entry queue between classification and execution
   dec_item_type slot_ff [2];
   dec_item_type dec_in;
   logic         rd_ptr_ff, wr_ptr_ff;
   logic [1:0]   count_ff;
   logic         push;
   op_class_type cls;

   // classify the opcode
   always_comb begin
      priority if (req_opcode <= OP_CMP) cls = CL_ALU;
      else if (req_opcode == OP_XCHG) cls = req_src_is_imm ? CL_NOP : CL_XCHG;
      else if (req_opcode == OP_PUSH) cls = CL_PUSH;
      else if (req_opcode == OP_POP) cls = CL_POP;
      else if (req_opcode == OP_MULA || req_opcode == OP_MULB)
         cls = req_dst_is_mem ? CL_NOP : CL_MUL;
      else if (req_opcode == OP_DIVA || req_opcode == OP_DIVB)
         cls = req_dst_is_mem ? CL_NOP : CL_DIV;
      else if (req_opcode >= OP_JMPA && req_opcode <= OP_JMPB) cls = CL_JUMP;
      else if (req_opcode == OP_HALT) cls = CL_HALT;
      else cls = CL_ILLEGAL;
      dec_in.cls        = cls;
      dec_in.opcode     = req_opcode;
      dec_in.src_field  = req_src_field;
      dec_in.dst_reg    = req_dst_reg;
      dec_in.addr       = 13'(req_dst_reg) + 13'(req_mem_offset);
      dec_in.src_is_imm = req_src_is_imm;
      dec_in.dst_is_mem = req_dst_is_mem;
   end

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
      if (push) slot_ff[wr_ptr_ff] <= dec_in;
   end

   `include "register_memory_execute_unit_top_macros.svh"
   `RMEU_ASSERT_IMP(a_no_pop_empty, clock, reset, q_pop, q_valid, "pop from empty queue")
   `RMEU_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= 2'd2, "queue count overflow")
   `RMEU_ASSERT_NEXT(a_push_fills, clock, reset, push && !q_pop, q_valid, "push lost")
endmodule

FILE: hdl/rmeu_back.sv
module rmeu_back #(
   parameter int MemWords = rmeu_pkg::MemWordsDefault,
   parameter int NumRegs  = rmeu_pkg::NumRegsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  rmeu_pkg::dec_item_type q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_result_value,
   output logic [1:0]             rsp_flag_code,
   output logic                   rsp_branch_taken,
   output logic signed [31:0]     rsp_branch_target,
   output logic                   rsp_halted,
   output logic [1:0]             rsp_error
);
   import rmeu_pkg::*;
   localparam int AW = $clog2(MemWords);
   localparam int RW = $clog2(NumRegs);

   exec_state_type state_ff, state_in;
   dec_item_type   it_ff;
   logic [31:0]    regs_ff [NumRegs];
   logic [AW-1:0]  clr_addr_ff;
   logic [31:0]    a_ff, b_ff;
   logic [63:0]    prod_ff;
   logic [31:0]    q_ff, rem_ff, dvd_ff;
   logic [5:0]     dcnt_ff;
   logic           neg_ff;

   logic           mem_we;
   logic [AW-1:0]  mem_wa, mem_ra;
   logic [31:0]    mem_wd, mem_rd, mem_word;

   rmeu_ram #(.Width(32), .Depth(MemWords)) u_ram (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
      .rd_addr(mem_ra), .rd_data(mem_rd)
   );

   // decode helpers
   logic [31:0] sp_word;
   logic signed [32:0] sp_val;
   logic        src_reg_ok, dst_reg_ok, addr_ok, sp_ok;
   logic [RW-1:0] src_idx, dst_idx;
   logic [AW-1:0] sp_idx, rd_addr_sel;
   logic [1:0]  flagc;
   logic        cond;
   logic [31:0] src_val_w;
   logic signed [32:0] bval;

   assign sp_word    = regs_ff[SpReg];
   assign sp_val     = val_of(sp_word);
   assign sp_ok      = !sp_word[31] && (33'(sp_word[30:0]) < 33'(MemWords));
   assign sp_idx     = sp_word[AW-1:0];
   assign src_reg_ok = 32'(it_ff.src_field) < 32'(NumRegs);
   assign dst_reg_ok = 32'(it_ff.dst_reg) < 32'(NumRegs);
   assign addr_ok    = 32'(it_ff.addr) < 32'(MemWords);
   assign src_idx    = it_ff.src_field[RW-1:0];
   assign dst_idx    = it_ff.dst_reg[RW-1:0];
   assign flagc      = flag_of(regs_ff[FlagReg]);
   assign src_val_w  = it_ff.src_is_imm ? 32'(it_ff.src_field) : regs_ff[src_idx];
   assign bval       = it_ff.src_is_imm ? 33'(it_ff.src_field) : val_of(regs_ff[src_idx]);
   assign rd_addr_sel = (it_ff.cls == CL_POP) ? sp_idx : it_ff.addr[AW-1:0];
   assign mem_ra     = rd_addr_sel;
   assign mem_word   = mem_rd;

   always_comb begin
      unique case (it_ff.opcode)
         OP_JE:   cond = (flagc == 2'd0);
         OP_JNE:  cond = (flagc != 2'd0);
         OP_JG:   cond = (flagc == 2'd1);
         OP_JGE:  cond = (flagc == 2'd0) || (flagc == 2'd1);
         OP_JL:   cond = (flagc == 2'd2);
         OP_JLE:  cond = (flagc == 2'd0) || (flagc == 2'd2);
         default: cond = 1'b1;
      endcase
   end

   // ALU on registered operands
   logic signed [32:0] av, bv2;
   logic signed [63:0] alu_r;
   always_comb begin
      av  = val_of(a_ff);
      bv2 = $signed(33'(b_ff[31:0]));
      bv2 = (it_ff.src_is_imm) ? $signed({1'b0, b_ff}) : val_of(b_ff);
      unique case (it_ff.opcode)
         OP_ADD:  alu_r = 64'(av) + 64'(bv2);
         OP_MOV:  alu_r = 64'(bv2);
         OP_AND:  alu_r = 64'(av & bv2);
         OP_XOR:  alu_r = 64'(av ^ bv2);
         OP_OR:   alu_r = 64'(av | bv2);
         default: alu_r = 64'(av) - 64'(bv2);
      endcase
   end

   // response registers
   logic        rv_ff, rv_in;
   logic [31:0] res_ff, res_in, tgt_ff, tgt_in;
   logic        tk_ff, tk_in, hl_ff, hl_in;
   logic [1:0]  er_ff, er_in, fl_ff, fl_in;

   // register file write ports
   logic        rf_we1, rf_we2;
   logic [RW-1:0] rf_wa1, rf_wa2;
   logic [31:0] rf_wd1, rf_wd2;
   logic        ld_ab, start_mul, start_div;

   always_comb begin
      state_in = state_ff;
      q_pop = 1'b0;
      rv_in = 1'b0; res_in = 32'd0; tgt_in = 32'd0; tk_in = 1'b0;
      hl_in = 1'b0; er_in = ERR_NONE; fl_in = flagc;
      rf_we1 = 1'b0; rf_wa1 = '0; rf_wd1 = '0;
      rf_we2 = 1'b0; rf_wa2 = '0; rf_wd2 = '0;
      mem_we = 1'b0; mem_wa = '0; mem_wd = '0;
      ld_ab = 1'b0; start_mul = 1'b0; start_div = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            // zero one memory word per cycle after reset
            mem_we = 1'b1; mem_wa = clr_addr_ff;
            if (clr_addr_ff == AW'(MemWords - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               state_in = ST_RD1;
            end
         end
         ST_RD1: begin
            // memory read issued here; decide the simple classes
            state_in = ST_DONE;
            unique case (it_ff.cls)
               CL_ALU, CL_XCHG: begin
                  if (!it_ff.src_is_imm && !src_reg_ok) er_in = ERR_RANGE;
                  else if (it_ff.dst_is_mem && !addr_ok) er_in = ERR_RANGE;
                  else if (!it_ff.dst_is_mem && !dst_reg_ok) er_in = ERR_RANGE;
                  else state_in = ST_EXEC;
               end
               CL_PUSH: begin
                  if (it_ff.dst_is_mem) begin
                     rf_we1 = 1'b1; rf_wa1 = RW'(SpReg);
                     rf_wd1 = word_of(64'(sp_val) - 64'sd1);
                  end else if ((!it_ff.src_is_imm && !src_reg_ok) || !sp_ok) begin
                     er_in = ERR_RANGE;
                  end else begin
                     mem_we = 1'b1; mem_wa = sp_idx; mem_wd = word_of(64'(bval));
                     res_in = 32'(val_of(word_of(64'(bval))));
                     rf_we1 = 1'b1; rf_wa1 = RW'(SpReg);
                     rf_wd1 = word_of(64'(sp_val) - 64'sd1);
                  end
               end
               CL_POP: begin
                  if (it_ff.dst_is_mem || it_ff.src_is_imm) begin
                     rf_we1 = 1'b1; rf_wa1 = RW'(SpReg);
                     rf_wd1 = word_of(64'(sp_val) + 64'sd1);
                  end else if (!src_reg_ok || !sp_ok) er_in = ERR_RANGE;
                  else state_in = ST_EXEC;
               end
               CL_MUL, CL_DIV: begin
                  if (!it_ff.src_is_imm && !src_reg_ok) er_in = ERR_RANGE;
                  else if (it_ff.cls == CL_DIV && bval == 33'sd0) er_in = ERR_RANGE;
                  else if (it_ff.cls == CL_MUL) begin
                     start_mul = 1'b1; state_in = ST_MUL;
                  end else begin
                     start_div = 1'b1; state_in = ST_DIV;
                  end
               end
               CL_JUMP: begin
                  if (cond && !it_ff.dst_is_mem) begin
                     if (!it_ff.src_is_imm && !src_reg_ok) er_in = ERR_RANGE;
                     else begin
                        tk_in = 1'b1; tgt_in = 32'(64'(bval) - 64'sd1);
                     end
                  end
               end
               CL_HALT: hl_in = 1'b1;
               CL_NOP: ;
               default: er_in = ERR_ILLEGAL;
            endcase
            if (state_in == ST_DONE) rv_in = 1'b1;
            if (rf_we1 && rf_wa1 == RW'(FlagReg)) fl_in = flag_of(rf_wd1);
            if (state_in == ST_DONE) state_in = ST_IDLE;
            else state_in = (state_in == ST_EXEC) ? ST_RD2 : state_in;
         end
         ST_RD2: begin
            // memory data ready; latch operands
            ld_ab = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            rv_in = 1'b1;
            unique case (it_ff.cls)
               CL_XCHG: begin
                  if (it_ff.dst_is_mem) begin
                     mem_we = 1'b1; mem_wa = it_ff.addr[AW-1:0]; mem_wd = b_ff;
                  end else begin
                     rf_we2 = 1'b1; rf_wa2 = dst_idx; rf_wd2 = b_ff;
                  end
                  rf_we1 = 1'b1; rf_wa1 = src_idx; rf_wd1 = a_ff;
                  // register-to-register: later write wins on same index
                  res_in = 32'(val_of(b_ff));
                  if (!it_ff.dst_is_mem && src_idx == dst_idx) res_in = 32'(val_of(a_ff));
               end
               CL_POP: begin
                  rf_we1 = 1'b1; rf_wa1 = src_idx; rf_wd1 = a_ff;
                  res_in = 32'(val_of(a_ff));
                  rf_we2 = 1'b1; rf_wa2 = RW'(SpReg);
                  rf_wd2 = word_of(64'(val_of(src_idx == RW'(SpReg) ? a_ff : sp_word))
                                   + 64'sd1);
               end
               default: begin
                  res_in = 32'(val_of(word_of(alu_r)));
                  if (it_ff.opcode != OP_CMP) begin
                     if (it_ff.dst_is_mem) begin
                        mem_we = 1'b1; mem_wa = it_ff.addr[AW-1:0];
                        mem_wd = word_of(alu_r);
                     end else begin
                        rf_we1 = 1'b1; rf_wa1 = dst_idx; rf_wd1 = word_of(alu_r);
                     end
                  end
                  rf_we2 = 1'b1; rf_wa2 = RW'(FlagReg);
                  rf_wd2 = (word_of(alu_r) == 32'd0) ? 32'd0 :
                           (word_of(alu_r) [31] ? 32'd2 : 32'd1);
               end
            endcase
            fl_in = flagc;
            if (rf_we1 && rf_wa1 == RW'(FlagReg)) fl_in = flag_of(rf_wd1);
            if (rf_we2 && rf_wa2 == RW'(FlagReg)) fl_in = flag_of(rf_wd2);
         end
         ST_MUL: begin
            state_in = ST_WB;
         end
         ST_DIV: begin
            if (dcnt_ff == 6'd0) state_in = ST_WB2;
         end
         ST_WB: begin
            rf_we1 = 1'b1; rf_wa1 = '0;
            rf_wd1 = {prod_ff[30:0] != 31'd0 && neg_ff, prod_ff[30:0]};
            res_in = 32'(val_of(rf_wd1));
            rv_in = 1'b1; state_in = ST_IDLE;
            fl_in = flagc;
         end
         ST_WB2: begin
            rf_we1 = 1'b1; rf_wa1 = '0;
            rf_wd1 = {q_ff[30:0] != 31'd0 && neg_ff, q_ff[30:0]};
            res_in = 32'(val_of(rf_wd1));
            rv_in = 1'b1; state_in = ST_IDLE;
            fl_in = flagc;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // register file: reset values; later port wins
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= 32'd0;
         regs_ff[SpReg] <= 32'(SpReset);
      end else begin
         if (rf_we1) regs_ff[rf_wa1] <= rf_wd1;
         if (rf_we2) regs_ff[rf_wa2] <= rf_wd2;
      end
   end

   // control and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         rv_ff       <= 1'b0;
         dcnt_ff     <= 6'd0;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         if (state_ff == ST_CLEAR) clr_addr_ff <= clr_addr_ff + AW'(1);
         if (start_div) dcnt_ff <= 6'd31;
         else if (state_ff == ST_DIV && dcnt_ff != 6'd0) dcnt_ff <= dcnt_ff - 6'd1;
      end
      res_ff <= res_in; tgt_ff <= tgt_in; tk_ff <= tk_in; hl_ff <= hl_in;
      er_ff <= er_in; fl_ff <= fl_in;
      if (q_pop) it_ff <= q_item;
   end

   // operand latch, multiplier and restoring divider
   logic [32:0] trial;
   assign trial = {rem_ff, dvd_ff[31]} - {1'b0, b_ff};
   always_ff @(posedge clock) begin
      if (ld_ab) begin
         unique case (it_ff.cls)
            CL_XCHG: begin
               a_ff <= it_ff.dst_is_mem ? mem_word : regs_ff[dst_idx];
               b_ff <= regs_ff[src_idx];
            end
            CL_POP: a_ff <= mem_word;
            default: begin
               a_ff <= it_ff.dst_is_mem ? mem_word : regs_ff[dst_idx];
               b_ff <= src_val_w;
            end
         endcase
      end
      if (start_mul) begin
         prod_ff <= 64'(regs_ff[0][30:0]) *
                    64'(it_ff.src_is_imm ? 31'(it_ff.src_field) : src_val_w[30:0]);
         neg_ff  <= regs_ff[0][31] ^ (!it_ff.src_is_imm && src_val_w[31]);
      end
      if (start_div) begin
         dvd_ff <= {1'b0, regs_ff[0][30:0]};
         b_ff   <= {1'b0, it_ff.src_is_imm ? 31'(it_ff.src_field) : src_val_w[30:0]};
         rem_ff <= 32'd0;
         q_ff   <= 32'd0;
         neg_ff <= regs_ff[0][31] ^ (!it_ff.src_is_imm && src_val_w[31]);
      end else if (state_ff == ST_DIV) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            q_ff   <= {q_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], dvd_ff[31]};
            q_ff   <= {q_ff[30:0], 1'b0};
         end
         dvd_ff <= {dvd_ff[30:0], 1'b0};
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_result_value  = res_ff;
   assign rsp_flag_code     = fl_ff;
   assign rsp_branch_taken  = tk_ff;
   assign rsp_branch_target = tgt_ff;
   assign rsp_halted        = hl_ff;
   assign rsp_error         = er_ff;

   `include "register_memory_execute_unit_top_macros.svh"
   `RMEU_ASSERT_IMP(a_pop_idle, clock, reset, q_pop, state_ff == ST_IDLE, "pop while busy")
   `RMEU_ASSERT_IMP(a_taken_ok, clock, reset, rsp_valid && rsp_branch_taken, rsp_error == ERR_NONE, "taken with error")
   `RMEU_ASSERT_NEXT(a_one_resp, clock, reset, rsp_valid, !rsp_valid, "back-to-back responses")
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rmeu_pkg::*;

   localparam int NRegs  = NumRegsDefault;
   localparam int NWords = MemWordsDefault;

   typedef struct {
      logic [5:0]  opcode;
      logic [10:0] src_field;
      logic [4:0]  dst_reg;
      logic [7:0]  mem_offset;
      logic        src_is_imm;
      logic        dst_is_mem;
   } instr_type;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  flag;
      logic        taken;
      logic [31:0] target;
      logic        halted;
      logic [1:0]  err;
   } outcome_type;

   // architectural model of the unit plus the queue of pending outcomes
   class exec_scoreboard;
      logic [31:0] regs[NRegs];
      logic [31:0] dmem[NWords];
      outcome_type pending[$];
      int          fails;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (dmem[i]) dmem[i] = '0;
         regs[SpReg] = pack_word(SpReset);
         fails = 0;
      endfunction

      function longint unpack_word(logic [31:0] w);
         longint m;
         m = longint'(w[30:0]);
         return w[31] ? -m : m;
      endfunction

      function logic [31:0] pack_word(longint v);
         longint unsigned m;
         m = (v < 0) ? longint'(0) - v : v;
         if (m[30:0] == 31'd0) return '0;
         return {v < 0, m[30:0]};
      endfunction

      // register operand or immediate; false when the register is out of range
      function bit fetch_src(instr_type it, output longint b);
         b = 0;
         if (it.src_is_imm) begin
            b = longint'(it.src_field);
            return 1;
         end
         if (int'(it.src_field) >= NRegs) return 0;
         b = unpack_word(regs[it.src_field]);
         return 1;
      endfunction

      // execute one accepted instruction and queue its outcome
      function void note_transfer(instr_type it);
         outcome_type o;
         longint   a, b, r, sp;
         int       addr;
         logic [31:0] t, w;
         bit       cond;
         o = '{default: '0};
         case (it.opcode)
            OP_ADD, OP_SUB, OP_MOV, OP_AND, OP_XOR, OP_OR, OP_CMP, OP_XCHG: begin
               if (it.opcode == OP_XCHG && it.src_is_imm) begin
               end else if (!fetch_src(it, b)) begin
                  o.err = ERR_RANGE;
               end else begin
                  addr = int'(it.dst_reg) + int'(it.mem_offset);
                  if (it.dst_is_mem && addr >= NWords) o.err = ERR_RANGE;
                  else begin
                     t = it.dst_is_mem ? dmem[addr] : regs[it.dst_reg];
                     if (it.opcode == OP_XCHG) begin
                        w = regs[it.src_field];
                        if (it.dst_is_mem) dmem[addr] = w; else regs[it.dst_reg] = w;
                        regs[it.src_field] = t;
                        o.value = 32'(unpack_word(w));
                     end else begin
                        a = unpack_word(t);
                        case (it.opcode)
                           OP_ADD: r = a + b;
                           OP_MOV: r = b;
                           OP_AND: r = a & b;
                           OP_XOR: r = a ^ b;
                           OP_OR:  r = a | b;
                           default: r = a - b;
                        endcase
                        w = pack_word(r);
                        if (it.opcode != OP_CMP) begin
                           if (it.dst_is_mem) dmem[addr] = w; else regs[it.dst_reg] = w;
                        end
                        r = unpack_word(w);
                        o.value = 32'(r);
                        regs[FlagReg] = (r == 0) ? 32'd0 : (r > 0) ? 32'd1 : 32'd2;
                     end
                  end
               end
            end
            OP_PUSH: begin
               sp = unpack_word(regs[SpReg]);
               if (!it.dst_is_mem && (!fetch_src(it, b) || sp < 0 || sp >= NWords))
                  o.err = ERR_RANGE;
               else begin
                  if (!it.dst_is_mem) begin
                     dmem[sp] = pack_word(b);
                     o.value = 32'(unpack_word(dmem[sp]));
                  end
                  regs[SpReg] = pack_word(unpack_word(regs[SpReg]) - 1);
               end
            end
            OP_POP: begin
               sp = unpack_word(regs[SpReg]);
               if (!it.dst_is_mem && !it.src_is_imm &&
                   (int'(it.src_field) >= NRegs || sp < 0 || sp >= NWords))
                  o.err = ERR_RANGE;
               else begin
                  if (!it.dst_is_mem && !it.src_is_imm) begin
                     regs[it.src_field] = dmem[sp];
                     o.value = 32'(unpack_word(dmem[sp]));
                  end
                  // stack pointer read after the load
                  regs[SpReg] = pack_word(unpack_word(regs[SpReg]) + 1);
               end
            end
            OP_MULA, OP_MULB, OP_DIVA, OP_DIVB: begin
               if (it.dst_is_mem) begin
               end else if (!fetch_src(it, b)) o.err = ERR_RANGE;
               else begin
                  a = unpack_word(regs[0]);
                  if (it.opcode >= OP_DIVA && b == 0) o.err = ERR_RANGE;
                  else begin
                     r = (it.opcode >= OP_DIVA) ? a / b : a * b;
                     regs[0] = pack_word(r);
                     o.value = 32'(unpack_word(regs[0]));
                  end
               end
            end
            OP_JMPA, OP_JE, OP_JNE, OP_JG, OP_JGE, OP_JL, OP_JLE, OP_JMPB: begin
               a = unpack_word(regs[FlagReg]);
               case (it.opcode)
                  OP_JE:  cond = (a == 0);
                  OP_JNE: cond = (a != 0);
                  OP_JG:  cond = (a == 1);
                  OP_JGE: cond = (a == 0 || a == 1);
                  OP_JL:  cond = (a == 2);
                  OP_JLE: cond = (a == 0 || a == 2);
                  default: cond = 1;
               endcase
               if (cond && !it.dst_is_mem) begin
                  if (!fetch_src(it, b)) o.err = ERR_RANGE;
                  else begin
                     o.taken  = 1;
                     o.target = 32'(b - 1);
                  end
               end
            end
            OP_HALT: o.halted = 1;
            default: o.err = ERR_ILLEGAL;
         endcase
         a = unpack_word(regs[FlagReg]);
         o.flag = (a == 0) ? 2'd0 : (a == 1) ? 2'd1 : (a == 2) ? 2'd2 : 2'd3;
         pending.push_back(o);
      endfunction

      // compare one response transfer with the oldest outcome
      function void check_transfer(outcome_type got);
         outcome_type e;
         if (pending.size() == 0) begin
            $error("response with no instruction outstanding");
            fails++;
            return;
         end
         e = pending.pop_front();
         if (got.value !== e.value) begin
            $error("result_value exp %0d got %0d", $signed(e.value), $signed(got.value));
            fails++;
         end
         if (got.flag !== e.flag) begin
            $error("flag_code exp %0d got %0d", e.flag, got.flag);
            fails++;
         end
         if (got.taken !== e.taken) begin
            $error("branch_taken exp %0d got %0d", e.taken, got.taken);
            fails++;
         end
         if (got.target !== e.target) begin
            $error("branch_target exp %0d got %0d", $signed(e.target), $signed(got.target));
            fails++;
         end
         if (got.halted !== e.halted) begin
            $error("halted exp %0d got %0d", e.halted, got.halted);
            fails++;
         end
         if (got.err !== e.err) begin
            $error("error exp %0d got %0d", e.err, got.err);
            fails++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [5:0]  req_opcode = '0;
   logic [10:0] req_src_field = '0;
   logic [4:0]  req_dst_reg = '0;
   logic [7:0]  req_mem_offset = '0;
   logic        req_src_is_imm = 0;
   logic        req_dst_is_mem = 0;
   logic               rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic [1:0]         rsp_flag_code;
   logic               rsp_branch_taken;
   logic signed [31:0] rsp_branch_target;
   logic               rsp_halted;
   logic [1:0]         rsp_error;

   exec_scoreboard sb = new();

   always #5 clock = ~clock;

   register_memory_execute_unit_top u_top (.*);

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_transfer('{rsp_result_value, rsp_flag_code, rsp_branch_taken,
                             rsp_branch_target, rsp_halted, rsp_error});
   end

   // present one instruction and hold it until the unit takes it
   task automatic issue(instr_type it);
      start          <= 1;
      req_opcode     <= it.opcode;
      req_src_field  <= it.src_field;
      req_dst_reg    <= it.dst_reg;
      req_mem_offset <= it.mem_offset;
      req_src_is_imm <= it.src_is_imm;
      req_dst_is_mem <= it.dst_is_mem;
      do @(posedge clock); while (busy);
      sb.note_transfer(it);
   endtask

   task automatic pause(int cycles);
      start <= 0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic instr_type mk(logic [5:0] op, int src, int dst, int off,
                                    bit imm, bit mem);
      return '{op, 11'(src), 5'(dst), 8'(off), imm, mem};
   endfunction

   // mostly well-formed instructions, keeping the stack pointer usable
   function automatic instr_type random_instr();
      instr_type it;
      int sel;
      sel = $urandom_range(0, 99);
      it.src_is_imm = ($urandom_range(0, 9) < 3);
      it.dst_is_mem = ($urandom_range(0, 9) < 3);
      it.dst_reg    = 5'($urandom_range(0, 31));
      it.mem_offset = 8'($urandom);
      it.src_field  = ($urandom_range(0, 29) == 0 || it.src_is_imm) ?
                      11'($urandom) : 11'($urandom_range(0, 31));
      if (sel < 45)      it.opcode = 6'($urandom_range(OP_ADD, OP_CMP));
      else if (sel < 53) it.opcode = OP_XCHG;
      else if (sel < 67) it.opcode = (sel & 1) ? OP_PUSH : OP_POP;
      else if (sel < 75) it.opcode = 6'($urandom_range(OP_MULA, OP_DIVB));
      else if (sel < 90) it.opcode = 6'($urandom_range(OP_JMPA, OP_JMPB));
      else if (sel < 93) it.opcode = OP_HALT;
      else it.opcode = ($urandom_range(0, 3) == 0) ? 6'd7 : 6'($urandom_range(23, 62));
      // protect the stack pointer from garbage
      if (it.opcode == OP_XCHG || it.opcode == OP_POP) begin
         if (it.src_field == 11'(SpReg)) it.src_field = 11'(SpReg + 1);
         if (it.dst_reg == 5'(SpReg)) it.dst_reg = 5'(SpReg + 1);
      end else if (it.opcode <= OP_CMP && it.dst_reg == 5'(SpReg) && !it.dst_is_mem) begin
         it.opcode     = OP_MOV;
         it.src_is_imm = 1;
         it.src_field  = ($urandom_range(0, 19) == 0) ? 11'($urandom) :
                         11'($urandom_range(0, NWords - 1));
      end
      return it;
   endfunction

   initial begin
      instr_type it;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: operand extremes, every operation class, corner cases
      issue(mk(OP_MOV, 2047, 1, 0, 1, 0));
      issue(mk(OP_ADD, 1, 2, 0, 0, 0));
      issue(mk(OP_SUB, 2047, 3, 0, 1, 0));
      issue(mk(OP_AND, 3, 2, 0, 0, 0));
      issue(mk(OP_XOR, 3, 4, 0, 0, 0));
      issue(mk(OP_OR, 1, 3, 0, 0, 0));
      issue(mk(OP_CMP, 1, 1, 0, 0, 0));
      issue(mk(OP_MOV, 3, 31, 255, 0, 1));
      issue(mk(OP_ADD, 2047, 31, 255, 1, 1));
      issue(mk(OP_XCHG, 1, 3, 0, 0, 0));
      issue(mk(OP_XCHG, 2, 0, 7, 0, 1));
      issue(mk(OP_XCHG, 5, 3, 0, 1, 0));
      issue(mk(OP_ADD, 2047, 3, 0, 0, 0));
      issue(mk(OP_PUSH, 3, 0, 0, 0, 0));
      issue(mk(OP_PUSH, 9, 0, 0, 1, 1));
      issue(mk(OP_POP, 4, 0, 0, 0, 0));
      issue(mk(OP_POP, 4, 0, 0, 1, 0));
      issue(mk(OP_MULA, 2047, 0, 0, 1, 0));
      issue(mk(OP_MULB, 3, 0, 0, 0, 0));
      issue(mk(OP_DIVA, 0, 0, 0, 1, 0));
      issue(mk(OP_DIVB, 7, 0, 0, 1, 0));
      issue(mk(OP_DIVA, 7, 0, 0, 1, 1));
      for (int j = OP_JMPA; j <= OP_JMPB; j++) issue(mk(6'(j), 0, 0, 0, 1, j[0]));
      issue(mk(OP_JMPA, 1500, 0, 0, 0, 0));
      issue(mk(OP_HALT, 0, 0, 0, 0, 0));
      issue(mk(6'd7, 0, 0, 0, 0, 0));
      issue(mk(6'd62, 0, 0, 0, 0, 0));

      // random traffic
      for (int n = 0; n < 1200; n++) begin
         it = random_instr();
         issue(it);
         if (n == 800) drain();
         else if ((n < 400 || n > 600) && $urandom_range(0, 99) < 12)
            pause($urandom_range(1, 6));
      end

      drain();
      repeat (60) @(posedge clock);
      if (sb.fails == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
